### sv/gbc_pkg.sv
// shared widths, payload types and speed helpers for the gateway class codec
package gbc_pkg;

    localparam int CLASS_W = 8;
    localparam int IN_W    = 28;
    localparam int SPEED_W = 22;
    localparam int N_DOWN  = 32;
    localparam int N_UP    = 8;
    localparam int GROUP_N = 8;
    localparam int N_GROUP = N_DOWN / GROUP_N;
    localparam int SP_W    = $clog2(N_DOWN);
    localparam int U_W     = $clog2(N_UP);
    localparam int PROD_W  = SPEED_W + U_W;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [IN_W-1:0]    down_kbit;
        logic [IN_W-1:0]    up_kbit;
        logic [CLASS_W-1:0] class_in;
    } t_req;

    typedef struct packed {
        logic [CLASS_W-1:0] class_code;
        logic [SPEED_W-1:0] down_out_kbit;
        logic [SPEED_W-1:0] up_out_kbit;
    } t_rsp;

    // down speed for scale bit and exponent packed as {s, p}
    function automatic logic [SPEED_W-1:0] down_cand(input logic [SP_W-1:0] sp);
        logic [SPEED_W-1:0] base;
        base = sp[SP_W-1] ? SPEED_W'(96) : SPEED_W'(64);
        return base << sp[SP_W-2:0];
    endfunction

    // (u + 1) * down / 8
    function automatic logic [SPEED_W-1:0] up_cand(input logic [SPEED_W-1:0] down,
                                                   input logic [U_W-1:0] u);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(down) * (PROD_W'(u) + PROD_W'(1));
        return prod[PROD_W-1:U_W];
    endfunction

    function automatic logic [IN_W-1:0] abs_diff(input logic [IN_W-1:0] a,
                                                 input logic [IN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic t_rsp decode_class(input logic [CLASS_W-1:0] c);
        t_rsp r;
        r.class_code = c;
        if (c == '0) begin
            r.down_out_kbit = '0;
            r.up_out_kbit   = '0;
        end else begin
            r.down_out_kbit = down_cand(c[CLASS_W-1:U_W]);
            r.up_out_kbit   = up_cand(r.down_out_kbit, c[U_W-1:0]);
        end
        return r;
    endfunction

endpackage

### sv/gbc_stream_if.sv
// valid/ready request channel carrying one payload word
interface gbc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### sv/gbc_argmin.sv
// balanced compare tree returning the lowest index holding the smallest value
module gbc_argmin #(
    parameter int N = gbc_pkg::GROUP_N,
    parameter int W = gbc_pkg::IN_W
) (
    input  logic [W-1:0]         i_diff [N],
    output logic [W-1:0]         o_diff,
    output logic [$clog2(N)-1:0] o_idx
);
    localparam int L  = $clog2(N);
    localparam int IW = $clog2(N);

    logic [W-1:0]  d_lv [L+1][N];
    logic [IW-1:0] x_lv [L+1][N];

    always_comb begin
        for (int lv = 0; lv <= L; lv++) begin
            for (int j = 0; j < N; j++) begin
                d_lv[lv][j] = '0;
                x_lv[lv][j] = '0;
            end
        end
        for (int j = 0; j < N; j++) begin
            d_lv[0][j] = i_diff[j];
            x_lv[0][j] = IW'(j);
        end
        for (int lv = 0; lv < L; lv++) begin
            for (int j = 0; j < (N >> (lv + 1)); j++) begin
                // right side wins only when strictly smaller
                if (d_lv[lv][2*j+1] < d_lv[lv][2*j]) begin
                    d_lv[lv+1][j] = d_lv[lv][2*j+1];
                    x_lv[lv+1][j] = x_lv[lv][2*j+1];
                end else begin
                    d_lv[lv+1][j] = d_lv[lv][2*j];
                    x_lv[lv+1][j] = x_lv[lv][2*j];
                end
            end
        end
    end

    assign o_diff = d_lv[L][0];
    assign o_idx  = x_lv[L][0];
endmodule

### sv/gateway_bandwidth_class_codec_unit.sv
// gateway bandwidth class codec: six-stage pipeline, encode search and decode
// throughput: one request per cycle, limited by the per-stage valid/ready chain
// stages: down diffs, group argmin, final argmin, up diffs, up argmin, decode
// reset: synchronous active-low reset clears the stage valid bits only
module gateway_bandwidth_class_codec_unit #(
    parameter int GROUP_N = gbc_pkg::GROUP_N
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gbc_stream_if.sink   i_req,
    gbc_stream_if.source o_rsp
);
    localparam int IN_W    = gbc_pkg::IN_W;
    localparam int SPEED_W = gbc_pkg::SPEED_W;
    localparam int CLASS_W = gbc_pkg::CLASS_W;
    localparam int N_DOWN  = gbc_pkg::N_DOWN;
    localparam int N_UP    = gbc_pkg::N_UP;
    localparam int N_GROUP = N_DOWN / GROUP_N;
    localparam int SP_W    = gbc_pkg::SP_W;
    localparam int U_W     = gbc_pkg::U_W;
    localparam int GI_W    = $clog2(GROUP_N);
    localparam int G_W     = $clog2(N_GROUP);

    // stage valids and enables
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !r6_v || o_rsp.ready;
    assign en5 = !r5_v || en6;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign i_req.ready = en1;

    // stage 1: distance to every down candidate
    logic               r1_func;
    logic [IN_W-1:0]    r1_up;
    logic [CLASS_W-1:0] r1_cls;
    logic [IN_W-1:0]    r1_diff [N_DOWN];

    // stage 2: best of each group
    logic               r2_func;
    logic [IN_W-1:0]    r2_up;
    logic [CLASS_W-1:0] r2_cls;
    logic [IN_W-1:0]    r2_diff [N_GROUP];
    logic [GI_W-1:0]    r2_idx [N_GROUP];
    logic [IN_W-1:0]    n2_diff [N_GROUP];
    logic [GI_W-1:0]    n2_idx [N_GROUP];

    // stage 3: chosen down speed
    logic               r3_func;
    logic [IN_W-1:0]    r3_up;
    logic [CLASS_W-1:0] r3_cls;
    logic [SP_W-1:0]    r3_sp;
    logic [SPEED_W-1:0] r3_mdown;
    logic [G_W-1:0]     n3_g;
    logic [SP_W-1:0]    n3_sp;

    // stage 4: distance to every up candidate
    logic               r4_func;
    logic [CLASS_W-1:0] r4_cls;
    logic [SP_W-1:0]    r4_sp;
    logic [IN_W-1:0]    r4_diff [N_UP];

    // stage 5: class byte
    logic [CLASS_W-1:0] r5_cls;
    logic [U_W-1:0]     n5_u;

    // stage 6: response
    gbc_pkg::t_rsp      r6_rsp;

    for (genvar g = 0; g < N_GROUP; g++) begin : g_grp
        logic [IN_W-1:0] grp_diff [GROUP_N];
        for (genvar k = 0; k < GROUP_N; k++) begin : g_el
            assign grp_diff[k] = r1_diff[g*GROUP_N+k];
        end
        gbc_argmin #(.N(GROUP_N), .W(IN_W)) u_grp_min (
            .i_diff (grp_diff),
            .o_diff (n2_diff[g]),
            .o_idx  (n2_idx[g])
        );
    end

    gbc_argmin #(.N(N_GROUP), .W(IN_W)) u_down_min (
        .i_diff (r2_diff),
        .o_diff (),
        .o_idx  (n3_g)
    );
    assign n3_sp = {n3_g, r2_idx[n3_g]};

    gbc_argmin #(.N(N_UP), .W(IN_W)) u_up_min (
        .i_diff (r4_diff),
        .o_diff (),
        .o_idx  (n5_u)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_req.valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
            if (en6) r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_func <= i_req.payload.func;
            r1_up   <= i_req.payload.up_kbit;
            r1_cls  <= i_req.payload.class_in;
            for (int i = 0; i < N_DOWN; i++) begin
                r1_diff[i] <= gbc_pkg::abs_diff(
                    IN_W'(gbc_pkg::down_cand(SP_W'(i))), i_req.payload.down_kbit);
            end
        end
        if (en2) begin
            r2_func <= r1_func;
            r2_up   <= r1_up;
            r2_cls  <= r1_cls;
            r2_diff <= n2_diff;
            r2_idx  <= n2_idx;
        end
        if (en3) begin
            r3_func  <= r2_func;
            r3_up    <= r2_up;
            r3_cls   <= r2_cls;
            r3_sp    <= n3_sp;
            r3_mdown <= gbc_pkg::down_cand(n3_sp);
        end
        if (en4) begin
            r4_func <= r3_func;
            r4_cls  <= r3_cls;
            r4_sp   <= r3_sp;
            for (int u = 0; u < N_UP; u++) begin
                r4_diff[u] <= gbc_pkg::abs_diff(
                    IN_W'(gbc_pkg::up_cand(r3_mdown, U_W'(u))), r3_up);
            end
        end
        if (en5) begin
            if (r4_func == gbc_pkg::FUNC_DECODE) begin
                r5_cls <= r4_cls;
            end else begin
                r5_cls <= {r4_sp, n5_u};
            end
        end
        if (en6) begin
            r6_rsp <= gbc_pkg::decode_class(r5_cls);
        end
    end

    assign o_rsp.valid   = r6_v;
    assign o_rsp.payload = r6_rsp;

`ifndef ASSERT_OFF
    a_zero_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.payload.class_code == '0) |->
        (o_rsp.payload.down_out_kbit == '0) && (o_rsp.payload.up_out_kbit == '0))
        else $error("class zero response with nonzero speed");

    a_up_le_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.payload.up_out_kbit <= o_rsp.payload.down_out_kbit))
        else $error("up speed exceeds down speed");

    a_nonzero_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.payload.class_code != '0) |->
        (o_rsp.payload.down_out_kbit != '0))
        else $error("nonzero class with zero down speed");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r1_v |-> i_req.ready)
        else $error("request stalled with empty first stage");
`endif
endmodule
